FILE: sv/bse_pkg.sv
// bse_pkg: shared types for the bubble sort engine
// no dependencies; imported by bse_cmp, bse_store, bubble_sort_engine_core and tb_top
`default_nettype none

package bse_pkg;

    localparam int unsigned VALUE_W = 32;

    typedef logic signed [VALUE_W-1:0] value_t;

    // result of one compare-and-swap step
    typedef struct packed {
        logic   swap;    // held value was strictly greater
        value_t put;     // value written back to the store
        value_t keep;    // value carried on as the bubble
    } cmp_res_t;

endpackage

`default_nettype wire

FILE: sv/bse_cmp.sv
// bse_cmp: shared compare-and-swap unit of the sort engine
// depends on bse_pkg (value_t, cmp_res_t)
`default_nettype none

module bse_cmp (
    input  bse_pkg::value_t   held,
    input  bse_pkg::value_t   fetched,
    output bse_pkg::cmp_res_t res
);
    import bse_pkg::*;

    logic greater;

    // strictly greater only, keeps the sort stable
    assign greater = (held > fetched);

    always_comb
    begin
        res.swap = greater;
        if (greater)
        begin
            res.put  = fetched;
            res.keep = held;
        end
        else
        begin
            res.put  = held;
            res.keep = fetched;
        end
    end

endmodule

`default_nettype wire

FILE: sv/bse_store.sv
// bse_store: element memory, one write and one read port, registered read data
// depends on bse_pkg (value_t)
`default_nettype none

module bse_store #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  bse_pkg::value_t               wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output bse_pkg::value_t               rd_data
);
    import bse_pkg::*;

    value_t mem [DEPTH];
    value_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: sv/bubble_sort_engine_core.sv
// bubble_sort_engine_core: batch sorter for signed 32-bit values
// depends on bse_pkg, bse_store (element memory) and bse_cmp (compare unit)
// usage:
//   input channel (value, last, valid/ready): one element per transaction;
//   last = 1 closes the batch. elements past MAX_ELEMENTS are dropped, but a
//   dropped element flagged last still closes the batch.
//   output channel (value_res, last_res, overflow, res_valid/res_ready): the
//   batch in ascending signed order, last_res on the final element, overflow
//   on every element of a batch that lost elements.
// operation:
//   loading accepts one transaction per cycle. the sort runs bubble passes through
//   the single compare unit, using the read and the write port of the memory; each
//   pass fetches element 0, compares and swaps along the unsorted part and parks
//   the bubble at the pass end. emitting reads each element from memory, then
//   loads the output register. ready is low from the closing transaction until the
//   final sorted element is taken; a lone element skips the sort
// reset:
//   clears the element count, the drop flag and the sequencer; the memory
//   contents are not cleared and are never read before being written.
// stalls:
//   a result waits in the output register until res_ready; the sequencer
//   holds its place meanwhile and nothing is lost.
`default_nettype none

module bubble_sort_engine_core #(
    parameter int unsigned MAX_ELEMENTS = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  bse_pkg::value_t value,
    input  wire logic       last,
    input  wire logic       valid,
    output logic            ready,
    output bse_pkg::value_t value_res,
    output logic            last_res,
    output logic            overflow,
    output logic            res_valid,
    input  wire logic       res_ready
);
    import bse_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_ELEMENTS);
    localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);

    // sequencer codes
    localparam logic [2:0] S_LOAD  = 3'd0;  // taking elements
    localparam logic [2:0] S_START = 3'd1;  // fetch element 0 for the first pass
    localparam logic [2:0] S_FILL  = 3'd2;  // bubble loaded, fetch element 1
    localparam logic [2:0] S_CMP   = 3'd3;  // compare-and-swap step
    localparam logic [2:0] S_PEND  = 3'd4;  // park the bubble at pass end, fetch element 0 for the next pass
    localparam logic [2:0] S_EMRD  = 3'd5;  // fetch first sorted element
    localparam logic [2:0] S_EMLD  = 3'd6;  // load output register
    localparam logic [2:0] S_EMWT  = 3'd7;  // wait for the receiver

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pass_reg, pass_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic             dropped_reg, dropped_next;
    value_t           hold_reg, hold_next;
    value_t           out_value_reg, out_value_next;
    logic             out_last_reg, out_last_next;
    logic             res_valid_reg, res_valid_next;

    // memory port controls
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    value_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    value_t           rd_data;

    cmp_res_t         cmp;

    logic             in_fire;
    logic             out_fire;
    logic             has_room;
    logic [CNT_W-1:0] n_load;     // batch size after this element
    logic [CNT_W-1:0] lim;        // compares in the current pass
    logic [CNT_W:0]   j_plus1;
    logic [CNT_W:0]   j_plus2;
    logic [CNT_W:0]   pass_plus1;
    logic             last_cmp;

    bse_store #(
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // the bubble is compared against the element just read
    bse_cmp u_cmp (
        .held    (hold_reg),
        .fetched (rd_data),
        .res     (cmp)
    );

    assign in_fire    = valid && ready;
    assign out_fire   = res_valid_reg && res_ready;
    assign has_room   = (count_reg < CNT_W'(MAX_ELEMENTS));
    assign n_load     = has_room ? CNT_W'(count_reg + 1'b1) : count_reg;
    assign lim        = CNT_W'(count_reg - pass_reg);
    assign j_plus1    = {1'b0, j_reg} + 1'b1;
    assign j_plus2    = {1'b0, j_reg} + 2'd2;
    assign pass_plus1 = {1'b0, pass_reg} + 1'b1;
    assign last_cmp   = (j_plus1 == {1'b0, lim});

    assign ready = (state_reg == S_LOAD);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pass_next      = pass_reg;
        j_next         = j_reg;
        dropped_next   = dropped_reg;
        hold_next      = hold_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        res_valid_next = res_valid_reg;
        wr_en          = 1'b0;
        wr_addr        = count_reg[IDX_W-1:0];
        wr_data        = value;
        rd_en          = 1'b0;
        rd_addr        = '0;

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_fire)
                begin
                    if (has_room)
                    begin
                        wr_en      = 1'b1;
                        count_next = n_load;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (last)
                    begin
                        j_next    = '0;
                        pass_next = CNT_W'(1);
                        // a single element needs no sorting
                        state_next = (n_load > CNT_W'(1)) ? S_START : S_EMRD;
                    end
                end
            end

            S_START:
            begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = S_FILL;
            end

            S_FILL:
            begin
                hold_next  = rd_data;
                rd_en      = 1'b1;
                rd_addr    = IDX_W'(1);
                j_next     = '0;
                state_next = S_CMP;
            end

            S_CMP:
            begin
                // smaller one goes back at j, larger one keeps bubbling
                wr_en     = 1'b1;
                wr_addr   = j_reg[IDX_W-1:0];
                wr_data   = cmp.put;
                hold_next = cmp.keep;
                if (last_cmp)
                begin
                    state_next = S_PEND;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = j_plus2[IDX_W-1:0];
                    j_next  = j_plus1[CNT_W-1:0];
                end
            end

            S_PEND:
            begin
                // largest of this pass lands at its final place
                wr_en   = 1'b1;
                wr_addr = lim[IDX_W-1:0];
                wr_data = hold_reg;
                j_next  = '0;
                if (pass_plus1 == {1'b0, count_reg})
                begin
                    state_next = S_EMRD;
                end
                else
                begin
                    pass_next  = pass_plus1[CNT_W-1:0];
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    state_next = S_FILL;
                end
            end

            S_EMRD:
            begin
                rd_en      = 1'b1;
                rd_addr    = j_reg[IDX_W-1:0];
                state_next = S_EMLD;
            end

            S_EMLD:
            begin
                out_value_next = rd_data;
                out_last_next  = (j_plus1 == {1'b0, count_reg});
                res_valid_next = 1'b1;
                state_next     = S_EMWT;
            end

            S_EMWT:
            begin
                if (out_fire)
                begin
                    res_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        state_next   = S_LOAD;
                    end
                    else
                    begin
                        j_next     = j_plus1[CNT_W-1:0];
                        rd_en      = 1'b1;
                        rd_addr    = j_plus1[IDX_W-1:0];
                        state_next = S_EMLD;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            pass_reg      <= '0;
            j_reg         <= '0;
            dropped_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pass_reg      <= pass_next;
            j_reg         <= j_next;
            dropped_reg   <= dropped_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        hold_reg      <= hold_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    assign value_res = out_value_reg;
    assign last_res  = out_last_reg;
    assign overflow  = dropped_reg;
    assign res_valid = res_valid_reg;

    // no input transaction while a result is on offer
    a_no_load_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !ready)
        else $error("input ready while a result is pending");

    // the closing transaction always starts the sort or emit phase
    a_close_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && ready && last) |=> !ready)
        else $error("input still ready after batch close");

    // overflow only reported for a full store
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && overflow) |-> (count_reg == CNT_W'(MAX_ELEMENTS)))
        else $error("overflow flagged on a batch below capacity");

    // final result empties the block
    a_empty_after_batch: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready && last_res) |=> (count_reg == '0 && !overflow && ready))
        else $error("block not emptied after final result");

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// tb_top: self-checking testbench for bubble_sort_engine_core
// depends on bse_pkg and the core; holds a batch-sort tracker class and the drive tasks
`timescale 1ns / 1ps

module tb_top;

    import bse_pkg::*;

    localparam int unsigned CAPACITY   = 16;
    localparam int unsigned ITEM_GOAL  = 380;
    localparam int unsigned IDLE_PCT   = 29;
    localparam int unsigned DRAIN_CYC  = 400;
    localparam value_t      VAL_MIN    = 32'sh8000_0000;
    localparam value_t      VAL_MAX    = 32'sh7fff_ffff;

    typedef struct {
        value_t value;
        bit     last;
        bit     overflow;
    } sorted_elem_t;

    // shapes of random batch content
    typedef enum int {
        FILL_ANY,
        FILL_NARROW,
        FILL_EDGE,
        FILL_FEW,
        FILL_RISING,
        FILL_FALLING
    } fill_t;

    // tracks the batch being loaded and the sorted elements still owed
    class sorted_batch_tracker;
        value_t       held [CAPACITY];
        int unsigned  held_count;
        bit           lost_some;
        sorted_elem_t sorted_due [$];
        int unsigned  fails;

        function new();
            held_count = 0;
            lost_some  = 0;
            fails      = 0;
        endfunction

        // one accepted input transaction
        function void record_element(value_t v, bit closes);
            value_t       tmp;
            sorted_elem_t e;
            if (held_count < CAPACITY) begin
                held[held_count] = v;
                held_count++;
            end
            else begin
                lost_some = 1;
            end
            if (!closes)
                return;
            // stable bubble sort, swap only on strictly greater
            for (int p = 1; p < held_count; p++) begin
                for (int j = 0; j + p < held_count; j++) begin
                    if (held[j] > held[j+1]) begin
                        tmp       = held[j];
                        held[j]   = held[j+1];
                        held[j+1] = tmp;
                    end
                end
            end
            for (int k = 0; k < held_count; k++) begin
                e.value    = held[k];
                e.last     = (k + 1 == held_count);
                e.overflow = lost_some;
                sorted_due.push_back(e);
            end
            held_count = 0;
            lost_some  = 0;
        endfunction

        // one accepted output transaction against the oldest owed element
        function void check_sorted(value_t v, bit l, bit o);
            sorted_elem_t want;
            if (sorted_due.size() == 0) begin
                $error("unexpected result transaction: value_res %0d last_res %0b overflow %0b",
                       v, l, o);
                fails++;
                return;
            end
            want = sorted_due.pop_front();
            if (v !== want.value) begin
                $error("value_res: expected %0d, got %0d", want.value, v);
                fails++;
            end
            if (l !== want.last) begin
                $error("last_res: expected %0b, got %0b", want.last, l);
                fails++;
            end
            if (o !== want.overflow) begin
                $error("overflow: expected %0b, got %0b", want.overflow, o);
                fails++;
            end
        endfunction

        function int unsigned owed();
            return sorted_due.size();
        endfunction
    endclass

    logic   clk;
    logic   rst_n;
    value_t value;
    logic   last;
    logic   valid;
    logic   ready;
    value_t value_res;
    logic   last_res;
    logic   overflow;
    logic   res_valid;
    logic   res_ready;

    sorted_batch_tracker tracker;
    int unsigned         items_sent;
    bit                  calm;     // no idling on either side while set

    bubble_sort_engine_core #(
        .MAX_ELEMENTS(CAPACITY)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .last      (last),
        .valid     (valid),
        .ready     (ready),
        .value_res (value_res),
        .last_res  (last_res),
        .overflow  (overflow),
        .res_valid (res_valid),
        .res_ready (res_ready)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // both channels sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (res_valid && res_ready)
                tracker.check_sorted(value_res, last_res, overflow);
            if (valid && ready)
                tracker.record_element(value, last);
        end
    end

    // receiver: random back-pressure, none during the calm stretch
    always @(negedge clk)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else if (calm)
            res_ready <= 1'b1;
        else
            res_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // one input transaction, with random idle cycles in front
    task automatic send_element(value_t v, bit closes);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            valid <= 1'b0;
            @(negedge clk);
        end
        value <= v;
        last  <= closes;
        valid <= 1'b1;
        do
            @(posedge clk);
        while (!ready);
        items_sent++;
    endtask

    function automatic value_t pick_value(fill_t fill, int k, value_t base, value_t pool [3]);
        value_t edges [5];
        edges[0] = VAL_MIN;
        edges[1] = VAL_MAX;
        edges[2] = 0;
        edges[3] = -1;
        edges[4] = 1;
        case (fill)
            FILL_NARROW:  return $signed($urandom_range(0, 20)) - 10;
            FILL_EDGE:    return edges[$urandom_range(0, 4)];
            FILL_FEW:     return pool[$urandom_range(0, 2)];
            FILL_RISING:  return base + k * 7;
            FILL_FALLING: return base - k * 7;
            default:      return $urandom;
        endcase
    endfunction

    task automatic send_random_batch();
        int unsigned n;
        int unsigned r;
        fill_t       fill;
        value_t      base;
        value_t      pool [3];
        r = $urandom_range(0, 99);
        if (r < 10)
            n = 1;
        else if (r < 22)
            n = CAPACITY;
        else if (r < 32)
            n = $urandom_range(CAPACITY + 1, CAPACITY + 4);
        else
            n = $urandom_range(2, CAPACITY - 1);
        fill = fill_t'($urandom_range(0, 5));
        base = $urandom;
        for (int i = 0; i < 3; i++)
            pool[i] = $urandom;
        for (int k = 0; k < n; k++)
            send_element(pick_value(fill, k, base, pool), k == n - 1);
    endtask

    initial
    begin
        value_t extremes [5];
        tracker    = new();
        items_sent = 0;
        calm       = 1'b0;
        rst_n      = 1'b0;
        valid      = 1'b0;
        value      = '0;
        last       = 1'b0;
        res_ready  = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // single-element batch at the negative extreme
        send_element(VAL_MIN, 1'b1);

        // extremes in one batch
        extremes[0] = VAL_MAX;
        extremes[1] = VAL_MIN;
        extremes[2] = 0;
        extremes[3] = -1;
        extremes[4] = 1;
        for (int k = 0; k < 5; k++)
            send_element(extremes[k], k == 4);

        // store full: the closing transaction itself is dropped but still closes
        for (int k = 0; k <= CAPACITY; k++)
            send_element(VAL_MAX - k, k == CAPACITY);

        // random batches, with one stretch free of idling
        while (items_sent < ITEM_GOAL) begin
            calm = (items_sent >= 200 && items_sent < 260);
            send_random_batch();
        end
        calm = 1'b0;
        @(negedge clk);
        valid <= 1'b0;

        while (tracker.owed() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        if (tracker.fails == 0)
            $display("bubble_sort_engine_core: match");
        else
            $display("bubble_sort_engine_core: mismatch");
        $finish;
    end

    // watchdog
    initial
    begin
        #3_000_000;
        $display("bubble_sort_engine_core: mismatch");
        $finish;
    end

endmodule

FILE: bubble_sort_engine_core.f
sv/bse_pkg.sv
sv/bse_cmp.sv
sv/bse_store.sv
sv/bubble_sort_engine_core.sv
tb/sv/tb_top.sv
